[rtl/art_pkg.sv]
package art_pkg;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int unsigned CFG_SPACE_START = 0;
  localparam int unsigned CFG_SPACE_END   = 1;

  localparam int unsigned FLD_W  = 48;
  localparam int unsigned FLAG_W = 8;
  localparam int unsigned FID_W  = 32;

endpackage

[rtl/art_ram.sv]
module art_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/address_range_table.sv]
// Address range table: a sorted table of non-overlapping address ranges.
// Input channel in_*: one request per beat (lookup, find free gap, insert).
// Result channel out_*: exactly one result beat per request.
// Config channel cfg_*: writes space_start (index 0) and space_end (index 1);
// a config beat takes precedence over a request offered in the same cycle.
// One request is processed at a time; in_ready is low while it runs.
// Each table entry is one word of a single-port-write RAM with registered
// read, so every table step is an address state followed by a data state.
// Insert: a search pass, a shift pass moving entries up one slot, then merge
// checks with the next and previous neighbors, each merge followed by a
// shift-down pass.
// The result is held in an output register until out_ready takes it;
// the next request is accepted once that result beat has left.
// Reset empties the table at once (entry count to zero); the stored
// words are not cleared since entries beyond the count are never read.
// space_start resets to 0 and space_end to all ones.
module address_range_table
  import art_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [FLD_W-1:0]  in_address,
  input  logic [FLD_W-1:0]  in_length,
  input  logic [FLAG_W-1:0] in_range_flags,
  input  logic [FLAG_W-1:0] in_mmu_flags,
  input  logic              in_file_backed,
  input  logic [FID_W-1:0]  in_file_id,
  input  logic [FLD_W-1:0]  in_file_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [FLD_W-1:0]  out_out_start,
  output logic [FLD_W-1:0]  out_out_size,
  output logic [FLAG_W-1:0] out_out_flags,
  output logic [FLAG_W-1:0] out_out_mmu_flags,
  output logic              out_out_file_backed,
  output logic [FID_W-1:0]  out_out_file_id,
  output logic [FLD_W-1:0]  out_out_file_offset,
  output logic [1:0]        out_merged_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [FLD_W-1:0]  cfg_data
);

  localparam int unsigned IW  = $clog2(MAX_RANGES);
  localparam int unsigned CW  = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned EW  = 2 * AW + 2 * FLAG_W + 1 + FID_W + AW;
  localparam logic [AW-1:0] AMAX = {AW{1'b1}};

  typedef struct packed {
    logic [AW-1:0]     start;
    logic [AW-1:0]     size;
    logic [FLAG_W-1:0] flags;
    logic [FLAG_W-1:0] mmu;
    logic              fb;
    logic [FID_W-1:0]  fid;
    logic [AW-1:0]     offs;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LK_RD, S_LK_CHK,
    S_FF_RD, S_FF_CHK0, S_FF_CHK, S_FF_END,
    S_IN_RD, S_IN_CHK, S_SH_RD, S_SH_WR, S_IN_PUT,
    S_MN_RD, S_MN_CHK, S_MP_RD, S_MP_CHK,
    S_RM_RD, S_RM_WR, S_FIN_RD, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [1:0]    merged_r;
  logic          after_next_r;
  logic [AW-1:0] sstart_r, send_r;
  logic [AW-1:0] a_r;
  logic [1:0]    req_r;
  logic [AW-1:0] addr_r, len_r;
  entry_t        new_r;
  logic [1:0]    st_r;
  entry_t        res_r;
  logic          res_full_r;
  logic          out_valid_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rd;
  logic [EW-1:0] rd_bits;

  art_ram #(.WIDTH(EW), .DEPTH(MAX_RANGES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_bits)
  );
  assign rd = entry_t'(rd_bits);

  function automatic logic [AW-1:0] sat_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW] ? AMAX : s[AW-1:0];
  endfunction

  function automatic logic compat(entry_t a, entry_t b);
    logic [AW-1:0] o;
    o = a.offs + a.size;
    if (sat_add(a.start, a.size) != b.start) return 1'b0;
    if (a.flags != b.flags || a.mmu != b.mmu || a.fb != b.fb) return 1'b0;
    if (!a.fb) return 1'b1;
    return (a.fid == b.fid) && (o == b.offs);
  endfunction

  logic [AW-1:0] top_rd;
  logic [AW-1:0] a_t;
  assign top_rd = sat_add(rd.start, rd.size);
  assign a_t    = (a_r < top_rd) ? top_rd : a_r;

  // single shared compare unit for the find-free walk
  logic [AW-1:0] cmp_a, cmp_b;
  logic          fit;
  logic [AW-1:0] gap;
  always_comb begin
    cmp_a = a_r;
    cmp_b = (state_r == S_FF_END) ? send_r : rd.start;
    gap = cmp_b - cmp_a;
    fit = (cmp_a < cmp_b) && (gap >= len_r);
  end

  // shared merge check: lower entry first, upper entry second
  entry_t ja, jb, merged_entry;
  logic   join_ok;
  always_comb begin
    ja = new_r;
    jb = rd;
    if (state_r == S_MP_CHK) begin
      ja = rd;
      jb = new_r;
    end
    join_ok = compat(ja, jb);
    merged_entry = ja;
    merged_entry.size = sat_add(ja.size, jb.size);
  end

  logic [AW-1:0] hint_a;
  entry_t        res_init;
  logic [1:0]    st_init;
  assign hint_a = (in_address[AW-1:0] != '0) ? in_address[AW-1:0] : sstart_r;
  always_comb begin
    res_init = '0;
    st_init  = ST_MISS;
    if (req_t'(in_req_type) == REQ_FIND && cnt_r == '0) begin
      res_init.start = hint_a;
      st_init = ST_OK;
    end else if (req_t'(in_req_type) == REQ_INSERT && cnt_r >= CW'(MAX_RANGES)) begin
      st_init = ST_FULL;
    end
  end

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[IW-1:0];
    wdata = new_r;
    raddr = idx_r[IW-1:0];
    case (state_r)
      S_SH_WR: begin
        we = 1'b1;
        waddr = idx_r[IW-1:0] + 1'b1;
        wdata = rd;
      end
      S_IN_PUT: begin
        we = 1'b1;
        waddr = pos_r[IW-1:0];
        wdata = new_r;
      end
      S_RM_RD: begin
        raddr = idx_r[IW-1:0] + 1'b1;
      end
      S_RM_WR: begin
        we = 1'b1;
        wdata = rd;
      end
      S_MN_CHK: begin
        we = join_ok;
        waddr = pos_r[IW-1:0];
        wdata = merged_entry;
      end
      S_MP_CHK: begin
        we = join_ok;
        waddr = idx_r[IW-1:0];
        wdata = merged_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sstart_r    <= '0;
      send_r      <= AMAX;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == 1'(CFG_SPACE_START)) sstart_r <= cfg_data[AW-1:0];
            else send_r <= cfg_data[AW-1:0];
          end else if (in_valid) begin
            req_r    <= in_req_type;
            addr_r   <= in_address[AW-1:0];
            len_r    <= in_length[AW-1:0];
            new_r.start <= in_address[AW-1:0];
            new_r.size  <= in_length[AW-1:0];
            new_r.flags <= in_range_flags;
            new_r.mmu   <= in_mmu_flags;
            new_r.fb    <= in_file_backed;
            new_r.fid   <= in_file_backed ? in_file_id : '0;
            new_r.offs  <= in_file_backed ? in_file_offset[AW-1:0] : '0;
            a_r      <= hint_a;
            idx_r    <= '0;
            pos_r    <= '0;
            merged_r <= '0;
            res_full_r <= 1'b0;
            res_r    <= res_init;
            st_r     <= st_init;
            case (req_t'(in_req_type))
              REQ_LOOKUP: state_r <= (cnt_r == '0) ? S_OUT : S_LK_RD;
              REQ_FIND: state_r <= (cnt_r == '0) ? S_OUT : S_FF_RD;
              REQ_INSERT: begin
                if (cnt_r >= CW'(MAX_RANGES)) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= (cnt_r == '0) ? S_IN_PUT : S_IN_RD;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_LK_RD: state_r <= S_LK_CHK;
        S_LK_CHK: begin
          if (addr_r >= rd.start && addr_r < top_rd) begin
            st_r <= ST_OK;
            res_r <= rd;
            res_full_r <= 1'b1;
            state_r <= S_OUT;
          end else if (idx_r + 1'b1 == cnt_r) begin
            state_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_LK_RD;
          end
        end
        S_FF_RD: state_r <= (idx_r == '0) ? S_FF_CHK0 : S_FF_CHK;
        S_FF_CHK0: begin
          if (rd.start != sstart_r && fit) begin
            st_r <= ST_OK;
            res_r.start <= a_r;
            state_r <= S_OUT;
          end else begin
            a_r <= a_t;
            if (cnt_r == CW'(1)) begin
              state_r <= S_FF_END;
            end else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_FF_RD;
            end
          end
        end
        S_FF_CHK: begin
          // prev top already folded into a_r; check gap to this start
          if (fit) begin
            st_r <= ST_OK;
            res_r.start <= a_r;
            state_r <= S_OUT;
          end else begin
            a_r <= a_t;
            if (idx_r + 1'b1 == cnt_r) begin
              state_r <= S_FF_END;
            end else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_FF_RD;
            end
          end
        end
        S_FF_END: begin
          if (fit) begin
            st_r <= ST_OK;
            res_r.start <= a_r;
          end
          state_r <= S_OUT;
        end
        S_IN_RD: state_r <= S_IN_CHK;
        S_IN_CHK: begin
          if (rd.start <= addr_r) begin
            pos_r <= idx_r + 1'b1;
            if (idx_r + 1'b1 == cnt_r) begin
              state_r <= S_IN_PUT;
            end else begin
              idx_r <= idx_r + 1'b1;
              state_r <= S_IN_RD;
            end
          end else begin
            idx_r <= cnt_r - 1'b1;
            state_r <= S_SH_RD;
          end
        end
        S_SH_RD: state_r <= S_SH_WR;
        S_SH_WR: begin
          if (idx_r == pos_r) begin
            state_r <= S_IN_PUT;
          end else begin
            idx_r <= idx_r - 1'b1;
            state_r <= S_SH_RD;
          end
        end
        S_IN_PUT: begin
          cnt_r <= cnt_r + 1'b1;
          if (pos_r + 1'b1 < cnt_r + 1'b1) begin
            idx_r <= pos_r + 1'b1;
            state_r <= S_MN_RD;
          end else if (pos_r != '0) begin
            idx_r <= pos_r - 1'b1;
            state_r <= S_MP_RD;
          end else begin
            idx_r <= pos_r;
            state_r <= S_FIN_RD;
          end
        end
        S_MN_RD: state_r <= S_MN_CHK;
        S_MN_CHK: begin
          if (join_ok) begin
            new_r.size <= merged_entry.size;
            merged_r <= merged_r + 1'b1;
            after_next_r <= 1'b1;
            idx_r <= pos_r + 1'b1;
            state_r <= S_RM_RD;
          end else if (pos_r != '0) begin
            idx_r <= pos_r - 1'b1;
            state_r <= S_MP_RD;
          end else begin
            idx_r <= pos_r;
            state_r <= S_FIN_RD;
          end
        end
        S_MP_RD: state_r <= S_MP_CHK;
        S_MP_CHK: begin
          if (join_ok) begin
            merged_r <= merged_r + 1'b1;
            after_next_r <= 1'b0;
            pos_r <= pos_r - 1'b1;
            idx_r <= pos_r;
            state_r <= S_RM_RD;
          end else begin
            idx_r <= pos_r;
            state_r <= S_FIN_RD;
          end
        end
        S_RM_RD: begin
          if (idx_r + 1'b1 >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1;
            if (after_next_r && pos_r != '0) begin
              idx_r <= pos_r - 1'b1;
              state_r <= S_MP_RD;
            end else begin
              idx_r <= pos_r;
              state_r <= S_FIN_RD;
            end
          end else begin
            state_r <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_RM_RD;
        end
        S_FIN_RD: state_r <= S_FIN;
        S_FIN: begin
          st_r <= ST_OK;
          res_r <= rd;
          res_full_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_status          = st_r;
  assign out_out_start       = FLD_W'(res_r.start);
  assign out_out_size        = res_full_r ? FLD_W'(res_r.size) : '0;
  assign out_out_flags       = res_full_r ? res_r.flags : '0;
  assign out_out_mmu_flags   = res_full_r ? res_r.mmu : '0;
  assign out_out_file_backed = res_full_r ? res_r.fb : 1'b0;
  assign out_out_file_id     = res_full_r ? res_r.fid : '0;
  assign out_out_file_offset = res_full_r ? FLD_W'(res_r.offs) : '0;
  assign out_merged_count    = (req_r == REQ_INSERT && st_r == ST_OK) ? merged_r : 2'd0;

endmodule
